FILE: hw/rtl/ufr_pkg.sv
// Shared types and constants for the UART frame receiver.
package ufr_pkg;

	// Serial and frame character codes
	localparam logic [7:0] CH_OPEN  = 8'h40;
	localparam logic [7:0] CH_CLOSE = 8'h26;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;
	localparam int unsigned CFG_DATA_W = 32;

	// Register reset values
	localparam logic [15:0] BIT_TICKS_RST     = 16'd104;
	localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd5000000;

	// Bit timing in half bit periods: first data sample and character end
	localparam logic [4:0] HALVES_FIRST = 5'd3;
	localparam logic [4:0] HALVES_END   = 5'd19;

	localparam int unsigned TICK_W = 20;

	typedef struct packed {
		logic [15:0] bit_ticks;
		logic [31:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic       has_char;
		logic [7:0] char_value;
		logic       first_char;
		logic       last_item;
		logic       frame_ok;
	} result_t;

endpackage

FILE: hw/rtl/uart_frame_receiver_unit.sv
// Top level of the UART 8N1 frame receiver with stream ports.
//
// Usage: each input beat on s_* is one sampling tick of the receive line
// (s_tdata bit 0 = line level, 1 = idle high). A low level while the bit
// receiver is idle starts a character; data bits are sampled LSB first at
// 1.5, 2.5 .. 8.5 bit periods and the character ends at 9.5 periods.
// Characters from '@' up to '&' stream out on m_* as a frame: m_tuser
// marks the opening character and success, m_tlast the closing beat. A
// timeout or the length limit closes the frame with frame_ok low; a
// timeout beat carries no character.
// Configuration: cfg_index 0 = bit_ticks, 1 = timeout_ticks, written on
// cfg_valid, always ready; write only between ticks of interest.
// Path: a result passes through the input register and then the result
// register before it shows on m_*. Throughput: one tick per cycle while
// m_* is not stalled, as the bit and frame state update in one step.
// Stall: while m_tvalid waits on m_tready, one more tick may sit in the
// input register; then s_tready drops until the result beat is taken.
// Reset: arst_n clears the valid flags and receiver state, not the data registers; registers return to 104 and 5000000.
module uart_frame_receiver_unit #(
	parameter int unsigned MAX_FRAME = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Tick stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [0] rx_level, [7:1] zero
	// Result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] char_value
	output logic [2:0]                     m_tuser,   // [0] has_char, [1] first_char, [2] frame_ok
	output logic                           m_tlast,   // last_item
	// Configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ufr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ufr_pkg::CFG_DATA_W-1:0] cfg_data
);

	ufr_pkg::cfg_t    cfg;
	ufr_pkg::result_t res;
	ufr_pkg::result_t out_q;
	logic             res_valid;
	logic             valid_s1;
	logic             level_s1;
	logic             out_valid_q;
	logic             advance;

	ufr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Process the held tick once the result register has room
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			level_s1 <= s_tdata[0];
		end
	end

	ufr_rx_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.level     (level_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register: release on a taken beat, load on a new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.char_value;
	assign m_tuser  = {out_q.frame_ok, out_q.first_char, out_q.has_char};
	assign m_tlast  = out_q.last_item;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_valid_q || m_tready)
		else $error("result produced while result register is full");

	a_step_needs_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1)
		else $error("core stepped without a held tick");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input taken while both stages are stalled");
`endif

endmodule

FILE: hw/rtl/ufr_cfg_regs.sv
// Configuration register file for the UART frame receiver.
module ufr_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ufr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ufr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ufr_pkg::cfg_t                     cfg
);

	logic [15:0] bit_ticks_q;
	logic [31:0] timeout_ticks_q;

	// Always ready; writes are registered
	assign cfg_ready = 1'b1;

	// Store register beats by index; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q     <= ufr_pkg::BIT_TICKS_RST;
			timeout_ticks_q <= ufr_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == ufr_pkg::REG_BIT_TICKS) begin
				bit_ticks_q <= cfg_data[15:0];
			end else if (cfg_index == ufr_pkg::REG_TIMEOUT_TICKS) begin
				timeout_ticks_q <= cfg_data[31:0];
			end
		end
	end

	assign cfg.bit_ticks     = bit_ticks_q;
	assign cfg.timeout_ticks = timeout_ticks_q;

endmodule

FILE: hw/rtl/ufr_rx_core.sv
// Bit sampling and frame tracking state, one tick per step.
module ufr_rx_core #(
	parameter int unsigned MAX_FRAME = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              level,
	input  ufr_pkg::cfg_t     cfg,
	output logic              res_valid,
	output ufr_pkg::result_t  res
);

	localparam int unsigned LEN_W = $clog2(MAX_FRAME);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_FRAME - 1);

	logic                        rx_busy_q;
	logic [ufr_pkg::TICK_W-1:0]  char_ticks_q;
	logic [3:0]                  bit_index_q;
	logic [7:0]                  shift_value_q;
	logic                        in_frame_q;
	logic [LEN_W-1:0]            frame_length_q;
	logic [31:0]                 frame_timer_q;

	logic                        rx_busy_d;
	logic [ufr_pkg::TICK_W-1:0]  char_ticks_d;
	logic [3:0]                  bit_index_d;
	logic [7:0]                  shift_value_d;
	logic                        in_frame_d;
	logic [LEN_W-1:0]            frame_length_d;
	logic [31:0]                 frame_timer_d;

	logic [31:0]                 timer_inc;
	logic [ufr_pkg::TICK_W-1:0]  ticks_inc;
	logic [LEN_W-1:0]            len_inc;
	logic [4:0]                  halves;
	logic [20:0]                 product;
	logic [ufr_pkg::TICK_W-1:0]  point;

	// Sample point in ticks: floor(bit_ticks * halves / 2)
	assign halves  = bit_index_q[3] ? ufr_pkg::HALVES_END
	                                : 5'({bit_index_q[2:0], 1'b0}) + ufr_pkg::HALVES_FIRST;
	assign product = 21'(cfg.bit_ticks) * 21'(halves);
	assign point   = product[20:1];

	assign ticks_inc = char_ticks_q + 1'b1;
	assign len_inc   = frame_length_q + 1'b1;
	assign timer_inc = (in_frame_q && (frame_timer_q != '1)) ? frame_timer_q + 1'b1
	                                                          : frame_timer_q;

	// Next state and result for the tick in the input register
	always_comb begin
		rx_busy_d      = rx_busy_q;
		char_ticks_d   = char_ticks_q;
		bit_index_d    = bit_index_q;
		shift_value_d  = shift_value_q;
		in_frame_d     = in_frame_q;
		frame_length_d = frame_length_q;
		frame_timer_d  = timer_inc;
		res_valid      = 1'b0;
		res            = '0;

		if (rx_busy_q) begin
			char_ticks_d = ticks_inc;
			if (!bit_index_q[3]) begin
				// Take one data bit, LSB first
				if (ticks_inc >= point) begin
					shift_value_d = shift_value_q | (8'(level) << bit_index_q[2:0]);
					bit_index_d   = bit_index_q + 1'b1;
				end
			end else if (ticks_inc >= point) begin
				// Character done; stop bit is not checked
				rx_busy_d     = 1'b0;
				char_ticks_d  = '0;
				bit_index_d   = '0;
				shift_value_d = '0;
				res.char_value = shift_value_q;
				if (!in_frame_q) begin
					if (shift_value_q == ufr_pkg::CH_OPEN) begin
						in_frame_d     = 1'b1;
						frame_length_d = LEN_W'(1);
						frame_timer_d  = '0;
						res_valid      = 1'b1;
						res.has_char   = 1'b1;
						res.first_char = 1'b1;
					end
				end else begin
					frame_length_d = len_inc;
					res_valid      = 1'b1;
					res.has_char   = 1'b1;
					if (shift_value_q == ufr_pkg::CH_CLOSE) begin
						in_frame_d    = 1'b0;
						res.last_item = 1'b1;
						res.frame_ok  = 1'b1;
					end else if (len_inc >= LEN_LIMIT) begin
						in_frame_d    = 1'b0;
						res.last_item = 1'b1;
					end
				end
			end
		end else begin
			// Timeout is checked only while the bit receiver is idle
			if (in_frame_q && (timer_inc >= cfg.timeout_ticks)) begin
				in_frame_d    = 1'b0;
				res_valid     = 1'b1;
				res.last_item = 1'b1;
			end
			if (!level) begin
				rx_busy_d     = 1'b1;
				char_ticks_d  = '0;
				bit_index_d   = '0;
				shift_value_d = '0;
			end
		end

		// Outside a frame the counters rest at zero
		if (!in_frame_d) begin
			frame_length_d = '0;
			frame_timer_d  = '0;
		end

		if (!step) begin
			res_valid = 1'b0;
		end
	end

	// Advance state once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_busy_q      <= 1'b0;
			char_ticks_q   <= '0;
			bit_index_q    <= '0;
			shift_value_q  <= '0;
			in_frame_q     <= 1'b0;
			frame_length_q <= '0;
			frame_timer_q  <= '0;
		end else if (step) begin
			rx_busy_q      <= rx_busy_d;
			char_ticks_q   <= char_ticks_d;
			bit_index_q    <= bit_index_d;
			shift_value_q  <= shift_value_d;
			in_frame_q     <= in_frame_d;
			frame_length_q <= frame_length_d;
			frame_timer_q  <= frame_timer_d;
		end
	end

`ifndef SYNTHESIS
	a_first_is_char: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.first_char |-> res.has_char && !res.last_item)
		else $error("opening result without character or with end mark");

	a_ok_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_ok |-> res.last_item && res.has_char)
		else $error("frame_ok set on a result that does not end the frame");

	a_timeout_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.has_char |-> res.last_item && !res.frame_ok && !rx_busy_q)
		else $error("empty result is not an idle timeout");

	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (frame_length_q == '0) && (frame_timer_q == '0))
		else $error("frame counters not cleared outside a frame");

	a_open_enters_frame: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.first_char |=> in_frame_q && (frame_length_q == LEN_W'(1)))
		else $error("opening character did not start a frame");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the UART frame receiver: line ticks in, frame beats checked.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAME_LIMIT = 2048;
	localparam logic [ufr_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'hFF;
	localparam int unsigned DRAIN_CYCLES = 8;

	// Tracks line ticks, predicts frame beats and checks them in order
	class frame_checker;
		logic [15:0] bit_ticks;
		logic [31:0] timeout_ticks;
		bit          rx_busy;
		bit [19:0]   char_ticks;
		bit [3:0]    bit_index;
		bit [7:0]    shift_value;
		bit          in_frame;
		bit [10:0]   frame_length;
		bit [31:0]   frame_timer;
		ufr_pkg::result_t due_beats[$];
		int unsigned mismatches, checked, predicted, frames_ok, frames_failed, timeouts;

		function new();
			bit_ticks = ufr_pkg::BIT_TICKS_RST;
			timeout_ticks = ufr_pkg::TIMEOUT_TICKS_RST;
			rx_busy = 0;
			char_ticks = '0;
			bit_index = '0;
			shift_value = '0;
			in_frame = 0;
			frame_length = '0;
			frame_timer = '0;
			mismatches = 0;
			checked = 0;
			predicted = 0;
			frames_ok = 0;
			frames_failed = 0;
			timeouts = 0;
		endfunction

		function void write_reg(logic [ufr_pkg::CFG_IDX_W-1:0] idx,
			logic [ufr_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ufr_pkg::REG_BIT_TICKS: begin
					bit_ticks = data[15:0];
				end
				ufr_pkg::REG_TIMEOUT_TICKS: begin
					timeout_ticks = data;
				end
				default: begin
				end
			endcase
		endfunction

		// Tick count at which a number of half bit periods has passed
		function int unsigned half_periods(int unsigned halves);
			return (32'(bit_ticks) * halves) >> 1;
		endfunction

		// Advance the receiver and frame state by one accepted tick
		function void take_tick(bit level);
			ufr_pkg::result_t beat;
			bit      emit;
			bit [7:0] ch;
			beat = '0;
			emit = 0;
			if (in_frame && frame_timer != '1)
				frame_timer++;
			if (rx_busy) begin
				char_ticks++;
				if (bit_index < 8) begin
					if (32'(char_ticks) >=
						half_periods(ufr_pkg::HALVES_FIRST + 2 * bit_index)) begin
						shift_value[bit_index[2:0]] = level;
						bit_index++;
					end
				end else if (32'(char_ticks) >= half_periods(ufr_pkg::HALVES_END)) begin
					ch = shift_value;
					rx_busy = 0;
					char_ticks = '0;
					bit_index = '0;
					shift_value = '0;
					if (!in_frame) begin
						// only the opening character starts a frame
						if (ch == ufr_pkg::CH_OPEN) begin
							in_frame = 1;
							frame_length = 1;
							frame_timer = '0;
							beat.has_char = 1;
							beat.char_value = ch;
							beat.first_char = 1;
							emit = 1;
						end
					end else begin
						frame_length++;
						beat.has_char = 1;
						beat.char_value = ch;
						emit = 1;
						if (ch == ufr_pkg::CH_CLOSE) begin
							in_frame = 0;
							beat.last_item = 1;
							beat.frame_ok = 1;
						end else if (frame_length >= FRAME_LIMIT - 1) begin
							in_frame = 0;
							beat.last_item = 1;
						end
					end
				end
			end else begin
				// timeout is looked at only while the bit receiver is idle
				if (in_frame && frame_timer >= timeout_ticks) begin
					in_frame = 0;
					beat.last_item = 1;
					emit = 1;
				end
				if (!level) begin
					rx_busy = 1;
					char_ticks = '0;
					bit_index = '0;
					shift_value = '0;
				end
			end
			if (!in_frame) begin
				frame_length = '0;
				frame_timer = '0;
			end
			if (emit) begin
				due_beats.push_back(beat);
				predicted++;
			end
		endfunction

		// Compare one result beat against the oldest prediction
		function void compare_beat(logic [7:0] data, logic [2:0] user, logic last);
			ufr_pkg::result_t got, want;
			got.has_char = user[0];
			got.char_value = data;
			got.first_char = user[1];
			got.last_item = last;
			got.frame_ok = user[2];
			if (due_beats.size() == 0) begin
				mismatches++;
				$display("%0t ns: result beat with none expected: has=%0b ch=%02h first=%0b last=%0b ok=%0b",
					$time, got.has_char, got.char_value, got.first_char, got.last_item,
					got.frame_ok);
				return;
			end
			want = due_beats.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				$display("%0t ns: expected has=%0b ch=%02h first=%0b last=%0b ok=%0b",
					$time, want.has_char, want.char_value, want.first_char, want.last_item,
					want.frame_ok);
				$display("%0t ns: actual   has=%0b ch=%02h first=%0b last=%0b ok=%0b",
					$time, got.has_char, got.char_value, got.first_char, got.last_item,
					got.frame_ok);
			end
			if (want.last_item) begin
				if (want.frame_ok)
					frames_ok++;
				else
					frames_failed++;
				if (!want.has_char)
					timeouts++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [7:0]                     m_tdata;
	logic [2:0]                     m_tuser;
	logic                           m_tlast;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ufr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ufr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	frame_checker scb = new();
	int unsigned  send_idle_pct = 37;
	int unsigned  rcv_idle_pct = 76;
	int unsigned  ticks_sent = 0;
	int unsigned  cur_bt = 32'(ufr_pkg::BIT_TICKS_RST);

	uart_frame_receiver_unit #(
		.MAX_FRAME(FRAME_LIMIT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset low at start, then release it
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	// Watch every handshake: config writes, ticks and result beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				scb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				scb.take_tick(s_tdata[0]);
			if (m_tvalid && m_tready)
				scb.compare_beat(m_tdata, m_tuser, m_tlast);
		end
	end

	// Drive one line tick, with a random gap ahead of it
	task automatic send_tick(input bit level);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, level};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
	endtask

	// Line level k ticks after the start bit of character ch
	function automatic bit line_level(bit [7:0] ch, int unsigned k);
		int unsigned slot;
		slot = (cur_bt >= 2) ? k / cur_bt : k;
		if (slot == 0)
			return 1'b0;
		else if (slot <= 8)
			return ch[slot-1];
		return 1'b1;
	endfunction

	// Tick index at which the receiver finishes a character
	function automatic int unsigned char_end();
		int unsigned e;
		e = (cur_bt * 19) >> 1;
		return (e < 9) ? 9 : e;
	endfunction

	// Send a whole character, then hold the line high for gap ticks
	task automatic send_char(input bit [7:0] ch, input int unsigned gap);
		int unsigned last;
		last = char_end();
		for (int unsigned k = 0; k <= last; k++)
			send_tick(line_level(ch, k));
		repeat (gap) send_tick(1'b1);
	endtask

	// Send the front part of a character only
	task automatic send_broken();
		bit [7:0]    ch;
		int unsigned cut;
		ch = 8'($urandom);
		cut = $urandom_range(1, char_end());
		for (int unsigned k = 0; k < cut; k++)
			send_tick(line_level(ch, k));
		repeat ($urandom_range(0, cur_bt)) send_tick(1'b1);
	endtask

	// Drop the tick stream and wait for every predicted beat
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (scb.due_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Idle the line until the bit receiver is free, then drain
	task automatic quiesce();
		do send_tick(1'b1); while (scb.rx_busy);
		settle();
	endtask

	task automatic wait_cfg();
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write both timing registers, optionally hitting the unused index first
	task automatic configure(input logic [15:0] bt, input logic [31:0] to, input bit spare);
		cfg_valid <= 1'b1;
		if (spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= $urandom;
			wait_cfg();
		end
		cfg_index <= ufr_pkg::REG_BIT_TICKS;
		cfg_data <= {16'b0, bt};
		wait_cfg();
		cfg_index <= ufr_pkg::REG_TIMEOUT_TICKS;
		cfg_data <= to;
		wait_cfg();
		cfg_valid <= 1'b0;
		cur_bt = 32'(bt);
	endtask

	// Mostly well-formed characters, plus line noise and cut-off characters
	task automatic run_round(input logic [15:0] bt, input logic [31:0] to, input bit spare);
		int unsigned t0, p0, sel, pick;
		bit [7:0]    ch;
		quiesce();
		configure(bt, to, spare);
		t0 = ticks_sent;
		p0 = scb.predicted;
		while (ticks_sent - t0 < 120 || scb.predicted - p0 < 3) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				pick = $urandom_range(0, 99);
				if (pick < 25)
					ch = ufr_pkg::CH_OPEN;
				else if (pick < 45)
					ch = ufr_pkg::CH_CLOSE;
				else
					ch = 8'($urandom);
				send_char(ch, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, cur_bt + 2));
			end else if (sel < 85) begin
				repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
			end else begin
				send_broken();
			end
		end
	endtask

	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// Directed: start a character at the reset bit period, finish it at a short one
		repeat (12) send_tick(1'b0);
		settle();
		configure(16'd2, 32'hFFFF_FFFF, 1'b1);
		quiesce();

		// Directed: discarded character, extreme bytes, nested open, clean close
		quiesce();
		configure(16'd2, 32'hFFFF_FFFF, 1'b1);
		send_char(8'h5A, 3);
		send_char(ufr_pkg::CH_OPEN, 0);
		send_char(8'h00, 0);
		send_char(8'hFF, 1);
		send_char(ufr_pkg::CH_OPEN, 0);
		send_char(8'h55, 0);
		send_char(8'hAA, 2);
		send_char(ufr_pkg::CH_CLOSE, 4);

		// Directed: zero timeout, also with a start bit on the timeout tick
		quiesce();
		configure(16'd2, 32'd0, 1'b0);
		send_char(ufr_pkg::CH_OPEN, 3);
		send_char(ufr_pkg::CH_OPEN, 0);
		send_char(8'h51, 3);

		// Directed: a character finishing past the limit still goes out
		quiesce();
		configure(16'd2, 32'd25, 1'b0);
		send_char(ufr_pkg::CH_OPEN, 0);
		send_char(8'h62, 0);
		send_char(8'h63, 5);

		// Directed: bit periods of one and zero ticks
		quiesce();
		configure(16'd1, 32'hFFFF_FFFF, 1'b0);
		send_char(ufr_pkg::CH_OPEN, 0);
		send_char(8'h80, 0);
		send_char(ufr_pkg::CH_CLOSE, 1);
		quiesce();
		configure(16'd0, 32'd1000, 1'b0);
		send_char(ufr_pkg::CH_OPEN, 0);
		send_char(8'h01, 0);
		send_char(ufr_pkg::CH_CLOSE, 2);

		// Widest bit period: start a character, then finish it at a short period
		quiesce();
		configure(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		for (int unsigned k = 0; k < 24; k++)
			send_tick(line_level(ufr_pkg::CH_OPEN, k));
		settle();
		configure(16'd2, 32'hFFFF_FFFF, 1'b0);
		quiesce();

		// Random, sender idles less than receiver
		run_round(16'd2, $urandom_range(40, 400), 1'b0);
		run_round(16'd3, 32'hFFFF_FFFF, 1'b1);

		// Random, roles of the two sides swapped
		quiesce();
		send_idle_pct = 76;
		rcv_idle_pct = 37;
		run_round(16'd1, $urandom_range(1, 60), 1'b0);
		run_round(16'd4, $urandom_range(200, 2000), 1'b0);

		// Random, full rate on both sides
		quiesce();
		send_idle_pct = 0;
		rcv_idle_pct = 0;
		run_round(16'd0, $urandom_range(0, 3), 1'b0);
		run_round(16'($urandom_range(2, 6)), $urandom_range(60, 600), 1'b1);

		settle();
		repeat (20) @(posedge clk);

		$display("Sent %0d line ticks at bit periods from 0 to 65535 ticks, timeouts 0 to max.",
			ticks_sent);
		$display("Checked %0d beats: %0d frames closed cleanly, %0d failed (%0d by timeout).",
			scb.checked, scb.frames_ok, scb.frames_failed, scb.timeouts);
		if (scb.mismatches == 0 && scb.due_beats.size() == 0)
			$display("uart_frame_receiver_unit test passed");
		else
			$display("uart_frame_receiver_unit test failed");
		$finish;
	end

	// Abort a hung run
	initial begin
		#2_000_000;
		$display("Timeout with %0d beats still expected.", scb.due_beats.size());
		$display("uart_frame_receiver_unit test failed");
		$finish;
	end

endmodule
